// File: src/contact_kirchhoff_matrix_core_defines.svh
// ----------------------------------------------------------------------------
// Contact matrix core: assertion macros
// Shared property wrappers for the checks at the end of the top level.
// ----------------------------------------------------------------------------
`ifndef CONTACT_KIRCHHOFF_MATRIX_CORE_DEFINES_SVH
`define CONTACT_KIRCHHOFF_MATRIX_CORE_DEFINES_SVH

// Same-cycle implication, sampled on clk, off during reset
`define KCM_CHECK(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off during reset
`define KCM_CHECK_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: src/kcm_pkg.sv
// ----------------------------------------------------------------------------
// Contact matrix package
// Opcodes, status codes, controller states and shared constants.
// ----------------------------------------------------------------------------
package kcm_pkg;

  // Fixed field widths
  localparam int CUT_BITS     = 24;
  localparam int CIN_BITS     = 24;
  localparam int ROW_BITS     = 6;
  localparam int VAL_BITS     = 7;
  localparam int STAT_BITS    = 2;
  localparam int SQ_BITS      = 2 * CUT_BITS;

  localparam logic [CUT_BITS-1:0] CUTOFF_RESET = 24'd1792;
  localparam logic [SQ_BITS-1:0]  CUT_SQ_RESET = 48'd3211264;

  // Input opcodes
  typedef enum logic [1:0] {
    OP_LOAD  = 2'd0,
    OP_READ  = 2'd1,
    OP_CLEAR = 2'd2
  } op_t;

  // Result status codes
  typedef enum logic [STAT_BITS-1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_DROP  = 2'd2
  } stat_t;

  // Controller states
  typedef enum logic [2:0] {
    S_IDLE,
    S_FETCH,
    S_SCAN,
    S_EMIT,
    S_RANGE
  } state_t;

  // Control broadcast to the ring of atom cells
  typedef struct packed {
    logic rotate;
    logic load;
  } ring_ctrl_t;

endpackage

// File: src/kcm_cell.sv
// ----------------------------------------------------------------------------
// Atom cell
// Holds one stored atom; takes a new atom on load when addressed, or the
// neighbor's atom when the ring rotates toward the head.
// ----------------------------------------------------------------------------
module kcm_cell #(
  parameter int COORD_BITS = 24,
  parameter int IW         = 6,
  parameter int CELL_IDX   = 0
) (
  input  logic                         clk,
  input  kcm_pkg::ring_ctrl_t          ctrl,
  input  logic [IW-1:0]                wr_idx,
  input  logic signed [COORD_BITS-1:0] ld_x,
  input  logic signed [COORD_BITS-1:0] ld_y,
  input  logic signed [COORD_BITS-1:0] ld_z,
  input  logic signed [COORD_BITS-1:0] nb_x,
  input  logic signed [COORD_BITS-1:0] nb_y,
  input  logic signed [COORD_BITS-1:0] nb_z,
  output logic signed [COORD_BITS-1:0] x,
  output logic signed [COORD_BITS-1:0] y,
  output logic signed [COORD_BITS-1:0] z
);
  import kcm_pkg::*;

  logic signed [COORD_BITS-1:0] x_r, y_r, z_r;
  logic signed [COORD_BITS-1:0] x_nxt, y_nxt, z_nxt;
  logic                         hit;

  assign hit = ctrl.load && (wr_idx == IW'(CELL_IDX));

  // Load has priority; loads only happen while the ring is at rest
  always_comb begin
    x_nxt = x_r;
    y_nxt = y_r;
    z_nxt = z_r;
    if (hit) begin
      x_nxt = ld_x;
      y_nxt = ld_y;
      z_nxt = ld_z;
    end else if (ctrl.rotate) begin
      x_nxt = nb_x;
      y_nxt = nb_y;
      z_nxt = nb_z;
    end
  end

  always_ff @(posedge clk) begin
    x_r <= x_nxt;
    y_r <= y_nxt;
    z_r <= z_nxt;
  end

  assign x = x_r;
  assign y = y_r;
  assign z = z_r;

endmodule

// File: src/kcm_dist.sv
// ----------------------------------------------------------------------------
// Distance compare pipeline
// Three stages: absolute axis differences, squares, sum against the squared
// cutoff. Any axis difference of 2^24 or more is never a contact.
// ----------------------------------------------------------------------------
module kcm_dist #(
  parameter int COORD_BITS = 24,
  parameter int IW         = 6
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_v,
  input  logic [IW-1:0]                       in_col,
  input  logic signed [COORD_BITS-1:0]        q_x,
  input  logic signed [COORD_BITS-1:0]        q_y,
  input  logic signed [COORD_BITS-1:0]        q_z,
  input  logic signed [COORD_BITS-1:0]        a_x,
  input  logic signed [COORD_BITS-1:0]        a_y,
  input  logic signed [COORD_BITS-1:0]        a_z,
  input  logic [kcm_pkg::SQ_BITS-1:0]         cut_sq,
  output logic                                out_v,
  output logic [IW-1:0]                       out_col,
  output logic                                out_hit
);
  import kcm_pkg::*;

  localparam int AW = COORD_BITS + 1;

  logic signed [AW-1:0] dx, dy, dz;
  logic [AW-1:0]        ax, ay, az;
  logic                 far;

  // Stage registers
  logic                 v1_r, v2_r, v3_r;
  logic [IW-1:0]        c1_r, c2_r, c3_r;
  logic                 far1_r, far2_r;
  logic [CUT_BITS-1:0]  ax_r, ay_r, az_r;
  logic [SQ_BITS-1:0]   sx_r, sy_r, sz_r;
  logic                 hit_r;
  logic [SQ_BITS+1:0]   sum;

  // Stage 1: magnitudes of the axis differences
  always_comb begin
    dx  = AW'(q_x) - AW'(a_x);
    dy  = AW'(q_y) - AW'(a_y);
    dz  = AW'(q_z) - AW'(a_z);
    ax  = dx[AW-1] ? AW'(-dx) : AW'(dx);
    ay  = dy[AW-1] ? AW'(-dy) : AW'(dy);
    az  = dz[AW-1] ? AW'(-dz) : AW'(dz);
    far = ((ax >> CUT_BITS) != '0) || ((ay >> CUT_BITS) != '0) ||
          ((az >> CUT_BITS) != '0);
  end

  // Stage 3 sum
  assign sum = (SQ_BITS+2)'(sx_r) + (SQ_BITS+2)'(sy_r) + (SQ_BITS+2)'(sz_r);

  // Valid flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      v1_r <= in_v;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  // Payload stages
  always_ff @(posedge clk) begin
    c1_r   <= in_col;
    far1_r <= far;
    ax_r   <= CUT_BITS'(ax);
    ay_r   <= CUT_BITS'(ay);
    az_r   <= CUT_BITS'(az);
    c2_r   <= c1_r;
    far2_r <= far1_r;
    sx_r   <= ax_r * ax_r;
    sy_r   <= ay_r * ay_r;
    sz_r   <= az_r * az_r;
    c3_r   <= c2_r;
    hit_r  <= !far2_r && (sum < (SQ_BITS+2)'(cut_sq));
  end

  assign out_v   = v3_r;
  assign out_col = c3_r;
  assign out_hit = hit_r;

endmodule

// File: src/contact_kirchhoff_matrix_core.sv
// ----------------------------------------------------------------------------
// Contact (Kirchhoff) matrix core
// Stores alpha-carbon atoms in a ring of cells and streams matrix rows.
// ----------------------------------------------------------------------------
// Load and clear items are taken in the idle state. A row read holds the input
// from the cycle it is accepted until its row has been sent and the core is
// back in the idle state.
// The ring of atom cells turns once to bring the requested atom to the head.
// It then turns a second time to stream every stored atom through the single
// three-stage distance unit, one pair per cycle, and the unit then drains.
// The row is then sent one entry per cycle while the result side accepts,
// from the contact-bit chain, since the diagonal count is known only after
// the whole row.
// A row beyond the stored atoms answers with one status item.
// The cutoff register may be written only while no row is in flight; its
// square is registered in the cycle after the write.
module contact_kirchhoff_matrix_core #(
  parameter int MAX_ATOMS  = 64,
  parameter int COORD_BITS = 24
) (
  input  logic        clk,
  input  logic        rst_n,
  // Input item
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [79:0] in_tdata,   // coord_x[23:0], coord_y[47:24], coord_z[71:48],
                                  // row_index[77:72], zero[79:78]
  input  logic [2:0]  in_tuser,   // opcode[1:0], is_alpha_carbon[2]
  // Result item
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // column_index[5:0], entry_value[12:6], zero[15:13]
  output logic        out_tlast,  // last_of_row
  output logic [1:0]  out_tuser,  // status[1:0]
  // Cutoff register
  input  logic        cfg_wr_en,
  input  logic [23:0] cfg_wr_data
);
  import kcm_pkg::*;
`include "contact_kirchhoff_matrix_core_defines.svh"

  localparam int IW = $clog2(MAX_ATOMS);
  localparam int CW = $clog2(MAX_ATOMS + 1);
  localparam logic [IW-1:0] LAST_STEP = IW'(MAX_ATOMS - 1);

  // Control state
  state_t            state_r, state_nxt;
  logic [CW-1:0]     count_r;
  logic              overflow_r;
  logic [CUT_BITS-1:0] cutoff_r;
  logic [SQ_BITS-1:0]  cut_sq_r;
  logic [IW-1:0]     step_r;
  logic              feed_r;
  logic [IW-1:0]     emit_r;
  logic [CW-1:0]     springs_r;
  logic [MAX_ATOMS-1:0] contact_r;
  logic [ROW_BITS-1:0]  row_r;
  logic signed [COORD_BITS-1:0] qx_r, qy_r, qz_r;

  // Output register
  logic                 out_valid_r;
  logic [ROW_BITS-1:0]  out_col_r;
  logic [VAL_BITS-1:0]  out_val_r;
  logic                 out_last_r;
  logic [STAT_BITS-1:0] out_stat_r;

  // Decode
  logic                in_acc;
  logic [1:0]          in_op;
  logic                in_alpha;
  logic [ROW_BITS-1:0] in_row;
  logic                room;
  logic                row_ok;
  logic                slot_free;

  // Ring
  ring_ctrl_t                   ring;
  logic [IW-1:0]                wr_idx;
  logic signed [COORD_BITS-1:0] ld_x, ld_y, ld_z;
  logic signed [COORD_BITS-1:0] cx [MAX_ATOMS];
  logic signed [COORD_BITS-1:0] cy [MAX_ATOMS];
  logic signed [COORD_BITS-1:0] cz [MAX_ATOMS];

  // Distance unit
  logic          feed_v;
  logic          dist_v;
  logic [IW-1:0] dist_col;
  logic          dist_hit;
  logic          scan_end;
  logic          emit_load;
  logic          emit_last;
  logic [VAL_BITS-1:0] emit_val;

  assign in_acc    = in_tvalid && in_tready;
  assign in_op     = in_tuser[1:0];
  assign in_alpha  = in_tuser[2];
  assign in_row    = in_tdata[77:72];
  assign room      = (CW+1)'(count_r) < (CW+1)'(MAX_ATOMS);
  assign row_ok    = 7'(in_row) < 7'(count_r);
  assign slot_free = !out_valid_r || out_tready;
  assign scan_end  = dist_v && (dist_col == LAST_STEP);
  assign emit_last = (7'(emit_r) + 7'd1) == 7'(count_r);

  assign ld_x = COORD_BITS'($signed(in_tdata[23:0]));
  assign ld_y = COORD_BITS'($signed(in_tdata[47:24]));
  assign ld_z = COORD_BITS'($signed(in_tdata[71:48]));
  assign wr_idx = count_r[IW-1:0];

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_acc && in_op == OP_READ) begin
          state_nxt = row_ok ? S_FETCH : S_RANGE;
        end
      end
      S_FETCH: begin
        if (step_r == LAST_STEP) begin
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        if (scan_end) begin
          state_nxt = S_EMIT;
        end
      end
      S_EMIT: begin
        if (slot_free && emit_last) begin
          state_nxt = S_IDLE;
        end
      end
      S_RANGE: begin
        if (slot_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // State outputs
  always_comb begin
    in_tready   = 1'b0;
    ring.rotate = 1'b0;
    ring.load   = 1'b0;
    feed_v      = 1'b0;
    emit_load   = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_tready = 1'b1;
        ring.load = in_tvalid && (in_op == OP_LOAD) && in_alpha && room;
      end
      S_FETCH: ring.rotate = 1'b1;
      S_SCAN: begin
        ring.rotate = feed_r;
        feed_v      = feed_r;
      end
      S_EMIT:  emit_load = slot_free;
      S_RANGE: emit_load = slot_free;
      default: in_tready = 1'b0;
    endcase
  end

  // Entry value for the current column
  always_comb begin
    if (7'(emit_r) == 7'(row_r)) begin
      emit_val = VAL_BITS'(springs_r);
    end else if (contact_r[0]) begin
      emit_val = '1;
    end else begin
      emit_val = '0;
    end
  end

  // Ring of atom cells, rotating toward cell 0
  for (genvar i = 0; i < MAX_ATOMS; i++) begin : g_cell
    localparam int NB = (i + 1) % MAX_ATOMS;
    kcm_cell #(
      .COORD_BITS (COORD_BITS),
      .IW         (IW),
      .CELL_IDX   (i)
    ) u_cell (
      .clk    (clk),
      .ctrl   (ring),
      .wr_idx (wr_idx),
      .ld_x   (ld_x),
      .ld_y   (ld_y),
      .ld_z   (ld_z),
      .nb_x   (cx[NB]),
      .nb_y   (cy[NB]),
      .nb_z   (cz[NB]),
      .x      (cx[i]),
      .y      (cy[i]),
      .z      (cz[i])
    );
  end

  kcm_dist #(
    .COORD_BITS (COORD_BITS),
    .IW         (IW)
  ) u_dist (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_v    (feed_v),
    .in_col  (step_r),
    .q_x     (qx_r),
    .q_y     (qy_r),
    .q_z     (qz_r),
    .a_x     (cx[0]),
    .a_y     (cy[0]),
    .a_z     (cz[0]),
    .cut_sq  (cut_sq_r),
    .out_v   (dist_v),
    .out_col (dist_col),
    .out_hit (dist_hit)
  );

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      overflow_r  <= 1'b0;
      cutoff_r    <= CUTOFF_RESET;
      cut_sq_r    <= CUT_SQ_RESET;
      step_r      <= '0;
      feed_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      cut_sq_r <= cutoff_r * cutoff_r;
      if (cfg_wr_en) begin
        cutoff_r <= cfg_wr_data;
      end
      // Store bookkeeping
      if (in_acc && in_op == OP_LOAD && in_alpha) begin
        if (room) begin
          count_r <= count_r + CW'(1);
        end else begin
          overflow_r <= 1'b1;
        end
      end else if (in_acc && in_op == OP_CLEAR) begin
        count_r    <= '0;
        overflow_r <= 1'b0;
      end
      // Ring step counter, one full turn per pass
      if (ring.rotate) begin
        step_r <= (step_r == LAST_STEP) ? '0 : step_r + IW'(1);
      end
      if (state_r == S_FETCH && step_r == LAST_STEP) begin
        feed_r <= 1'b1;
      end else if (feed_v && step_r == LAST_STEP) begin
        feed_r <= 1'b0;
      end
      // Output register
      if (emit_load) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Row datapath
  always_ff @(posedge clk) begin
    if (in_acc && in_op == OP_READ) begin
      row_r  <= in_row;
      emit_r <= '0;
    end
    if (state_r == S_FETCH) begin
      springs_r <= '0;
    end
    // Capture the query atom as it passes the head
    if (state_r == S_FETCH && (7'(step_r) == 7'(row_r))) begin
      qx_r <= cx[0];
      qy_r <= cy[0];
      qz_r <= cz[0];
    end
    // Contact bits shift in by column; count the stored off-diagonal hits
    if (dist_v) begin
      contact_r <= {dist_hit, contact_r[MAX_ATOMS-1:1]};
      if (dist_hit && (7'(dist_col) < 7'(count_r)) &&
          (7'(dist_col) != 7'(row_r))) begin
        springs_r <= springs_r + CW'(1);
      end
    end
    // Emit one entry per cycle while the result slot is free
    if (emit_load) begin
      if (state_r == S_RANGE) begin
        out_col_r  <= '0;
        out_val_r  <= '0;
        out_last_r <= 1'b1;
        out_stat_r <= ST_RANGE;
      end else begin
        out_col_r  <= ROW_BITS'(emit_r);
        out_val_r  <= emit_val;
        out_last_r <= emit_last;
        out_stat_r <= overflow_r ? ST_DROP : ST_OK;
        contact_r  <= contact_r >> 1;
        emit_r     <= emit_r + IW'(1);
      end
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {3'b000, out_val_r, out_col_r};
  assign out_tlast  = out_last_r;
  assign out_tuser  = out_stat_r;

  // Checks
  `KCM_CHECK(a_pipe_empty_idle, in_tready, !dist_v, "distance pipe busy while idle")
  `KCM_CHECK(a_count_bound, 1'b1, (CW+1)'(count_r) <= (CW+1)'(MAX_ATOMS), "atom count overrun")
  `KCM_CHECK(a_emit_range, state_r == S_EMIT, 7'(emit_r) < 7'(count_r), "emit past row end")
  `KCM_CHECK_NEXT(a_clear, in_acc && in_op == OP_CLEAR, count_r == '0 && !overflow_r, "clear missed")

endmodule

// File: tb/sv/tb_contact_kirchhoff_matrix_core.sv
// ----------------------------------------------------------------------------
// Contact matrix core testbench
// Streams atom loads, row reads and clears into the core, keeps its own
// atom store and cutoff, and checks every emitted matrix entry in order.
// Cutoff settings are changed between batches while the core is idle.
// ----------------------------------------------------------------------------
module tb_contact_kirchhoff_matrix_core;
  import kcm_pkg::*;

  localparam int          STORE_DEPTH = 64;
  localparam logic [1:0]  OP_UNUSED   = 2'd3;
  localparam logic [23:0] CUT_MAX     = 24'hFFFFFF;
  localparam int          RANDOM_GOAL = 120;

  // One input item and one matrix entry
  typedef struct {
    logic [1:0]         op;
    logic               ca;
    logic signed [23:0] x;
    logic signed [23:0] y;
    logic signed [23:0] z;
    logic [5:0]         row;
  } atom_cmd_t;

  typedef struct {
    logic [5:0] col;
    logic [6:0] val;
    logic       last;
    logic [1:0] stat;
  } entry_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [79:0] in_tdata = '0;
  logic [2:0]  in_tuser = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [15:0] out_tdata;
  logic        out_tlast;
  logic [1:0]  out_tuser;
  logic        cfg_wr_en = 1'b0;
  logic [23:0] cfg_wr_data = '0;

  contact_kirchhoff_matrix_core dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tlast   (out_tlast),
    .out_tuser   (out_tuser),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Shadow of the core state
  logic signed [23:0] atom_x [STORE_DEPTH];
  logic signed [23:0] atom_y [STORE_DEPTH];
  logic signed [23:0] atom_z [STORE_DEPTH];
  int                 atoms_held = 0;
  logic               atoms_dropped = 1'b0;
  logic [23:0]        cutoff_q = CUTOFF_RESET;

  atom_cmd_t pending_items[$];
  entry_t    row_entries_due[$];
  int        mismatches = 0;
  int        random_items = 0;

  // Append to the tail of the item and expectation queues
  function automatic void enqueue_cmd(atom_cmd_t c);
    pending_items = {pending_items, c};
  endfunction

  function automatic void enqueue_entry(entry_t e);
    row_entries_due = {row_entries_due, e};
  endfunction

  // Strict squared-distance compare against the squared cutoff
  function automatic bit atoms_touch(int a, int b);
    longint          dx, dy, dz;
    longint unsigned d2, c2;
    dx = longint'(atom_x[a]) - longint'(atom_x[b]);
    dy = longint'(atom_y[a]) - longint'(atom_y[b]);
    dz = longint'(atom_z[a]) - longint'(atom_z[b]);
    d2 = longint'(dx * dx) + longint'(dy * dy) + longint'(dz * dz);
    c2 = {40'd0, cutoff_q} * {40'd0, cutoff_q};
    return d2 < c2;
  endfunction

  // Update the shadow store and queue the entries a command produces
  function automatic void predict_matrix(atom_cmd_t c);
    entry_t e;
    entry_t row_q[$];
    int     springs;
    logic [1:0] st;
    springs = 0;
    st = atoms_dropped ? ST_DROP : ST_OK;
    case (c.op)
      OP_LOAD: begin
        if (c.ca) begin
          if (atoms_held < STORE_DEPTH) begin
            atom_x[atoms_held] = c.x;
            atom_y[atoms_held] = c.y;
            atom_z[atoms_held] = c.z;
            atoms_held++;
          end else begin
            atoms_dropped = 1'b1;
          end
        end
      end
      OP_CLEAR: begin
        atoms_held = 0;
        atoms_dropped = 1'b0;
      end
      OP_READ: begin
        if (int'(c.row) >= atoms_held) begin
          e = '{col: 6'd0, val: 7'd0, last: 1'b1, stat: ST_RANGE};
          enqueue_entry(e);
        end else begin
          for (int j = 0; j < atoms_held; j++) begin
            e.col  = 6'(j);
            e.val  = 7'd0;
            e.last = (j == atoms_held - 1);
            e.stat = st;
            if (j != int'(c.row) && atoms_touch(int'(c.row), j)) begin
              e.val = 7'h7F;
              springs++;
            end
            row_q = {row_q, e};
          end
          // diagonal holds the contact count
          row_q[c.row].val = 7'(springs);
          foreach (row_q[k]) enqueue_entry(row_q[k]);
        end
      end
      default: ;
    endcase
  endfunction

  // Fresh command with the given opcode and every other field random; callers override what matters
  function automatic atom_cmd_t make_cmd(logic [1:0] op);
    atom_cmd_t c;
    c.op  = op;
    c.ca  = 1'($urandom);
    c.x   = 24'($urandom);
    c.y   = 24'($urandom);
    c.z   = 24'($urandom);
    c.row = 6'($urandom);
    return c;
  endfunction

  task automatic push_load(logic ca, logic signed [23:0] x, logic signed [23:0] y,
                           logic signed [23:0] z);
    atom_cmd_t c;
    c = make_cmd(OP_LOAD);
    c.ca = ca;
    c.x = x;
    c.y = y;
    c.z = z;
    enqueue_cmd(c);
  endtask

  task automatic push_read(int row);
    atom_cmd_t c;
    c = make_cmd(OP_READ);
    c.row = 6'(row);
    enqueue_cmd(c);
  endtask

  function automatic logic signed [23:0] near_coord(int centre, int spread);
    return 24'(centre + int'($urandom_range(0, 2 * spread)) - spread);
  endfunction

  // Clear, a cluster of atoms with some noise, then several row reads
  task automatic queue_batch(int n_atoms, int spread, int n_reads);
    int cx, cy, cz, top;
    cx = int'($urandom_range(0, 16000000)) - 8000000;
    cy = int'($urandom_range(0, 16000000)) - 8000000;
    cz = int'($urandom_range(0, 16000000)) - 8000000;
    top = (n_atoms < STORE_DEPTH) ? n_atoms : STORE_DEPTH;
    enqueue_cmd(make_cmd(OP_CLEAR));
    random_items++;
    for (int i = 0; i < n_atoms; i++) begin
      if ($urandom_range(0, 7) == 0)
        push_load(1'b0, 24'($urandom), 24'($urandom), 24'($urandom));
      if ($urandom_range(0, 15) == 0)
        enqueue_cmd(make_cmd(OP_UNUSED));
      if ($urandom_range(0, 5) == 0)
        push_load(1'b1, 24'($urandom), 24'($urandom), 24'($urandom));
      else
        push_load(1'b1, near_coord(cx, spread), near_coord(cy, spread),
                  near_coord(cz, spread));
      random_items++;
    end
    for (int i = 0; i < n_reads; i++) begin
      if ($urandom_range(0, 4) == 0) push_read($urandom_range(0, 63));
      else push_read($urandom_range(0, top - 1));
      random_items++;
    end
  endtask

  // Wait until every item is taken and every entry has come back
  task automatic settle();
    while (pending_items.size() != 0 || in_tvalid || row_entries_due.size() != 0)
      @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic set_cutoff(logic [23:0] v);
    @(negedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    cutoff_q = v;
    repeat (2) @(negedge clk);
  endtask

  // Input driver: one item at a time, random gap after each
  atom_cmd_t in_cur;
  bit        in_taken = 1'b0;
  int        in_gap = 0;
  bit        in_steady = 1'b0;

  always @(negedge clk) begin : drive_in
    logic nxt;
    nxt = in_tvalid;
    if (rst_n && (!in_tvalid || in_taken)) begin
      in_taken = 1'b0;
      nxt = 1'b0;
      if (in_gap > 0) begin
        in_gap--;
      end else if (pending_items.size() > 0) begin
        in_cur = pending_items.pop_front();
        nxt = 1'b1;
        in_gap = in_steady ? 0 : $urandom_range(0, 4);
        if ($urandom_range(0, 19) == 0) in_steady = !in_steady;
      end
    end
    in_tvalid <= nxt;
    in_tdata  <= {2'b00, in_cur.row, in_cur.z, in_cur.y, in_cur.x};
    in_tuser  <= {in_cur.ca, in_cur.op};
  end

  always @(posedge clk) begin
    if (rst_n && in_tvalid && in_tready) begin
      predict_matrix(in_cur);
      in_taken = 1'b1;
    end
  end

  // Result side: random stall after each entry
  int out_wait = 0;
  bit out_steady = 1'b0;

  always @(negedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (out_wait > 0) begin
      out_wait--;
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  function automatic void report(string what, entry_t e, entry_t g);
    mismatches++;
    if (mismatches <= 10)
      $display(
        "%0t %s: exp col %0d val %0d last %0b st %0d, got col %0d val %0d last %0b st %0d",
        $realtime, what, e.col, $signed(e.val), e.last, e.stat,
        g.col, $signed(g.val), g.last, g.stat);
  endfunction

  // Monitor: compare each entry with the oldest expectation
  always @(posedge clk) begin : watch_out
    entry_t got, want;
    if (rst_n && out_tvalid && out_tready) begin
      got.col  = out_tdata[5:0];
      got.val  = out_tdata[12:6];
      got.last = out_tlast;
      got.stat = out_tuser;
      if (row_entries_due.size() == 0) begin
        want = '{col: 6'd0, val: 7'd0, last: 1'b0, stat: 2'd0};
        report("unexpected entry", want, got);
      end else begin
        want = row_entries_due.pop_front();
        if (got.col !== want.col || got.val !== want.val || got.last !== want.last ||
            got.stat !== want.stat)
          report("entry mismatch", want, got);
      end
      out_wait = out_steady ? 0 : $urandom_range(0, 4);
      if ($urandom_range(0, 19) == 0) out_steady = !out_steady;
    end
  end

  // Stimulus
  initial begin : stimulus
    int batch;
    int spread;
    logic [23:0] cut;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed: empty store, ignored items, extremes, cutoff boundary
    push_read(0);
    enqueue_cmd(make_cmd(OP_UNUSED));
    push_load(1'b0, 24'sd5, 24'sd5, 24'sd5);
    push_load(1'b1, 24'sd0, 24'sd0, 24'sd0);
    push_load(1'b1, 24'sd1791, 24'sd0, 24'sd0);       // just inside the cutoff
    push_load(1'b1, 24'sd0, 24'sd1792, 24'sd0);       // exactly at the cutoff
    push_load(1'b1, -24'sd8388608, -24'sd8388608, -24'sd8388608);
    push_load(1'b1, 24'sd8388607, 24'sd8388607, 24'sd8388607);
    push_load(1'b1, -24'sd8388608, 24'sd8388607, -24'sd1);
    push_load(1'b1, -24'sd8388508, -24'sd8388608, -24'sd8388608);
    for (int r = 0; r < 7; r++) push_read(r);
    push_read(7);                                     // first row past the store
    push_read(63);
    enqueue_cmd(make_cmd(OP_CLEAR));
    push_read(0);
    settle();

    // Random batches, cutoff changed between them
    batch = 0;
    while (random_items < RANDOM_GOAL) begin
      case (batch % 5)
        0: cut = 24'd0;
        1: cut = CUT_MAX;
        2: cut = 24'($urandom_range(1, 16777214));
        3: cut = 24'($urandom_range(64, 4096));
        default: cut = CUTOFF_RESET;
      endcase
      set_cutoff(cut);
      spread = (cut == 0) ? 1000 : ((cut > 24'd4000000) ? 4000000 : int'(cut));
      if (batch == 2) begin
        // fill the store past capacity, then read the far corners
        queue_batch(STORE_DEPTH + 2, spread, 3);
        push_read(STORE_DEPTH - 1);
        push_read(0);
        random_items += 2;
      end else begin
        queue_batch($urandom_range(1, 12), spread, $urandom_range(2, 5));
      end
      settle();
      batch++;
    end

    repeat (20) @(posedge clk);
    if (mismatches == 0)
      $display("contact_kirchhoff_matrix_core verification clean");
    else
      $display("contact_kirchhoff_matrix_core verification failed");
    $finish;
  end

  // Watchdog
  initial begin
    #2000000;
    $display("contact_kirchhoff_matrix_core verification failed");
    $finish;
  end

endmodule
